// File: src/rehc_pkg.sv
// ----------------------------------------------------------------------------
// rehc_pkg
// shared types and constants of the road entry hourly counter
// ----------------------------------------------------------------------------
package rehc_pkg;

  localparam int MAX_VEHICLES = 256;
  localparam int DAYS         = 30;
  localparam int HOURS        = 24;
  localparam int COUNT_WIDTH  = 16;
  localparam int COORD_WIDTH  = 10;

  // field widths of the stream items
  localparam int VID_FIELD_W = 8;
  localparam int HEAD_W      = 2;
  localparam int DAY_W       = 5;
  localparam int HOUR_W      = 5;

  localparam int NUM_BINS = DAYS * HOURS;
  localparam int BIN_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int VID_W    = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_WIDTH;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROAD_ENABLED    = 3'd0,
    CFG_ROAD_HORIZONTAL = 3'd1,
    CFG_ROAD_START_X    = 3'd2,
    CFG_ROAD_START_Y    = 3'd3,
    CFG_ROAD_END_X      = 3'd4,
    CFG_ROAD_END_Y      = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    REQ_OBSERVE = 1'b0,
    REQ_READ    = 1'b1
  } req_t;

  typedef enum logic [HEAD_W-1:0] {
    HEAD_RIGHT = 2'd0,
    HEAD_LEFT  = 2'd1,
    HEAD_UP    = 2'd2,
    HEAD_DOWN  = 2'd3
  } head_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic             obs;        // observation on an enabled road, id in range
    logic             can_enter;  // heading along the road and on the segment
    logic             on;         // position on the segment
    logic [VID_W-1:0] vid;
    logic             bin_ok;
    logic [BIN_W-1:0] bin;
  } cmd_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic clearing;  // histogram clear pass after reset
  } back_status_t;

endpackage

// File: src/road_entry_hourly_counter.sv
// ----------------------------------------------------------------------------
// road_entry_hourly_counter
// counts vehicle entries onto one road segment in day and hour bins
// ----------------------------------------------------------------------------
// path: a request passes the queue and the back end's current item register
//   into the result register; the back end reads, then writes the presence flag
//   and histogram memories of one item before it takes another from the queue
// reset: synchronous; road registers return to their defaults, presence flags
//   clear at once, then a clear pass zeroes every histogram bin with
//   s_tready held low (configuration writes are taken throughout)
module road_entry_hourly_counter (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [rehc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rehc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // vehicle_id[7:0], pos_x[17:8], pos_y[27:18], heading[29:28],
  // day_index[34:30], hour_index[39:35]
  input  logic [39:0]                      s_tdata,
  // req_type[0]
  input  logic                             s_tuser,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // entered[0], bin_count[16:1], zero fill [23:17]
  output logic [23:0]                      m_tdata
);
  import rehc_pkg::*;

  cmd_t         front_cmd;
  cmd_t         q_head;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  logic         push;
  back_status_t back_status;
  logic                   out_entered;
  logic [COUNT_WIDTH-1:0] out_bin_count;

  // front end: road registers and classification of each request
  rehc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_type   (s_tuser),
    .vehicle_id (s_tdata[7:0]),
    .pos_x      (s_tdata[17:8]),
    .pos_y      (s_tdata[27:18]),
    .heading    (s_tdata[29:28]),
    .day_index  (s_tdata[34:30]),
    .hour_index (s_tdata[39:35]),
    .cmd        (front_cmd)
  );

  // no transfer while the queue is full or the histogram is being cleared
  assign s_tready = !q_full && !back_status.clearing;
  assign push     = s_tvalid && s_tready;

  // two entry queue lets front and back stall independently
  rehc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back end: memory read, update and result register
  rehc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .status        (back_status),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_entered   (out_entered),
    .out_bin_count (out_bin_count)
  );

  // pack the result, zero fill up to whole bytes
  assign m_tdata = {7'd0, out_bin_count, out_entered};

endmodule

// File: src/rehc_ram.sv
// ----------------------------------------------------------------------------
// rehc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rehc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/rehc_front.sv
// ----------------------------------------------------------------------------
// rehc_front
// road registers and classification of incoming items
// ----------------------------------------------------------------------------
module rehc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rehc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rehc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_type,
  input  logic [rehc_pkg::VID_FIELD_W-1:0] vehicle_id,
  input  logic [rehc_pkg::COORD_WIDTH-1:0] pos_x,
  input  logic [rehc_pkg::COORD_WIDTH-1:0] pos_y,
  input  logic [rehc_pkg::HEAD_W-1:0]     heading,
  input  logic [rehc_pkg::DAY_W-1:0]      day_index,
  input  logic [rehc_pkg::HOUR_W-1:0]     hour_index,
  output rehc_pkg::cmd_t                  cmd
);
  import rehc_pkg::*;

  logic                   road_enabled;
  logic                   road_horizontal;
  logic [COORD_WIDTH-1:0] road_start_x;
  logic [COORD_WIDTH-1:0] road_start_y;
  logic [COORD_WIDTH-1:0] road_end_x;
  logic [COORD_WIDTH-1:0] road_end_y;

  logic on_h, on_v, on_seg, along;

  always_ff @(posedge clk) begin
    if (rst) begin
      road_enabled    <= 1'b0;
      road_horizontal <= 1'b1;
      road_start_x    <= '0;
      road_start_y    <= '0;
      road_end_x      <= '0;
      road_end_y      <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ROAD_ENABLED:    road_enabled    <= cfg_data[0];
        CFG_ROAD_HORIZONTAL: road_horizontal <= cfg_data[0];
        CFG_ROAD_START_X:    road_start_x    <= cfg_data[COORD_WIDTH-1:0];
        CFG_ROAD_START_Y:    road_start_y    <= cfg_data[COORD_WIDTH-1:0];
        CFG_ROAD_END_X:      road_end_x      <= cfg_data[COORD_WIDTH-1:0];
        CFG_ROAD_END_Y:      road_end_y      <= cfg_data[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    on_h   = (pos_x >= road_start_x) && (pos_x <= road_end_x) && (pos_y == road_start_y);
    on_v   = (pos_y >= road_start_y) && (pos_y <= road_end_y) && (pos_x == road_start_x);
    on_seg = road_horizontal ? on_h : on_v;
    along  = road_horizontal ? (heading == HEAD_RIGHT || heading == HEAD_LEFT)
                             : (heading == HEAD_UP || heading == HEAD_DOWN);

    cmd.obs       = (req_type == REQ_OBSERVE) && road_enabled &&
                    (32'(vehicle_id) < MAX_VEHICLES);
    cmd.on        = on_seg;
    cmd.can_enter = on_seg && along;
    cmd.vid       = vehicle_id[VID_W-1:0];
    cmd.bin_ok    = (32'(day_index) < DAYS) && (32'(hour_index) < HOURS);
    // day * hours + hour, constant multiply
    cmd.bin       = cmd.bin_ok ? BIN_W'(32'(day_index) * HOURS + 32'(hour_index)) : '0;
  end

endmodule

// File: src/rehc_queue.sv
// ----------------------------------------------------------------------------
// rehc_queue
// short fifo of classified items between front and back end
// ----------------------------------------------------------------------------
module rehc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rehc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output rehc_pkg::cmd_t head
);
  import rehc_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;

  assign full  = (cnt == QCNT_W'(QDEPTH));
  assign empty = (cnt == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop) else $error("queue pop while empty");

endmodule

// File: src/rehc_back.sv
// ----------------------------------------------------------------------------
// rehc_back
// presence flag and histogram update, result register, clear pass
// ----------------------------------------------------------------------------
module rehc_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  rehc_pkg::cmd_t                   q_head,
  output logic                             q_pop,
  output rehc_pkg::back_status_t           status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_entered,
  output logic [rehc_pkg::COUNT_WIDTH-1:0] out_bin_count
);
  import rehc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [BIN_W-1:0]  clr_addr;
  logic [MAX_VEHICLES-1:0] flag_valid;

  logic [VID_W-1:0]       rd_vid;
  logic [BIN_W-1:0]       rd_bin;
  logic [0:0]             flag_rd;
  logic [COUNT_WIDTH-1:0] bin_rd;
  logic                   clearing;
  logic                   out_free, fire;
  logic                   flag_cur, enter, flag_next, flag_we, inc;
  logic [COUNT_WIDTH-1:0] bin_new;
  logic                   bin_we;
  logic [BIN_W-1:0]       bin_waddr;
  logic [COUNT_WIDTH-1:0] bin_wdata;

  assign clearing        = (state == ST_CLEAR);
  assign status.clearing = clearing;
  assign q_pop           = (state == ST_IDLE) && !q_empty;

  // address from the queue head while idle, else hold the current item
  assign rd_vid = (state == ST_IDLE) ? q_head.vid : cur.vid;
  assign rd_bin = (state == ST_IDLE) ? q_head.bin : cur.bin;

  always_comb begin
    out_free  = !out_valid || out_ready;
    fire      = (state == ST_EXEC) && out_free;
    flag_cur  = flag_valid[cur.vid] & flag_rd[0];
    enter     = cur.obs && cur.can_enter && !flag_cur;
    flag_next = enter || (flag_cur && cur.on);
    flag_we   = fire && cur.obs;
    inc       = enter && cur.bin_ok && (bin_rd != COUNT_MAX);
    bin_new   = inc ? bin_rd + 1'b1 : bin_rd;
    bin_we    = clearing || (fire && inc);
    bin_waddr = clearing ? clr_addr : cur.bin;
    bin_wdata = clearing ? '0 : bin_new;
  end

  rehc_ram #(.WIDTH(1), .DEPTH(MAX_VEHICLES)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (cur.vid),
    .wdata (flag_next),
    .raddr (rd_vid),
    .rdata (flag_rd)
  );

  rehc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (rd_bin),
    .rdata (bin_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      flag_valid <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == BIN_W'(NUM_BINS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            cur   <= q_head;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            out_entered   <= enter;
            out_bin_count <= cur.bin_ok ? bin_new : '0;
            if (flag_we) begin
              flag_valid[cur.vid] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !q_pop) else $error("item taken during clear pass");

  a_flag_set_on_seg: assert property (@(posedge clk) disable iff (rst)
    (flag_we && flag_next) |-> cur.on) else $error("presence set off segment");

  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
    (fire && inc) |-> (bin_rd != COUNT_MAX)) else $error("bin count wrapped");

  a_result_follows_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EXEC) else $error("result without item");

endmodule

// File: tb/road_entry_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// road_entry_checker
// keeps its own copy of the road registers, presence flags and hourly bins,
// works out the result of every request transfer and compares it with the
// result transfers of the counter, oldest first
// ----------------------------------------------------------------------------
module road_entry_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rehc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rehc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  // vehicle_id[7:0], pos_x[17:8], pos_y[27:18], heading[29:28],
  // day_index[34:30], hour_index[39:35]
  input  logic [39:0]                     s_tdata,
  // req_type[0]
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // entered[0], bin_count[16:1], zero fill [23:17]
  input  logic [23:0]                     m_tdata,
  output int                              fail_count,
  output int                              pending
);
  import rehc_pkg::*;

  typedef struct packed {
    req_t                   req;
    logic [VID_FIELD_W-1:0] vid;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    head_t                  head;
    logic [DAY_W-1:0]       day;
    logic [HOUR_W-1:0]      hour;
  } sighting_t;

  typedef struct packed {
    logic                   entered;
    logic [COUNT_WIDTH-1:0] bin_count;
  } tally_t;

  logic                   road_en;
  logic                   road_horiz;
  logic [COORD_WIDTH-1:0] start_x;
  logic [COORD_WIDTH-1:0] start_y;
  logic [COORD_WIDTH-1:0] end_x;
  logic [COORD_WIDTH-1:0] end_y;

  logic                   present [MAX_VEHICLES];
  logic [COUNT_WIDTH-1:0] hourly  [NUM_BINS];

  tally_t expected_tallies [$];
  int     fails   = 0;
  int     waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  // applies one request to the mirrored state and returns its result
  function automatic tally_t tally_sighting(input sighting_t s);
    tally_t      r;
    logic        bin_ok;
    int unsigned bin;
    logic        on;
    logic        along;
    r      = '0;
    bin_ok = (s.day < DAYS) && (s.hour < HOURS);
    bin    = bin_ok ? s.day * HOURS + s.hour : 0;
    if (s.req == REQ_OBSERVE && road_en && s.vid < MAX_VEHICLES) begin
      if (road_horiz) begin
        on    = s.x >= start_x && s.x <= end_x && s.y == start_y;
        along = s.head == HEAD_RIGHT || s.head == HEAD_LEFT;
      end else begin
        on    = s.y >= start_y && s.y <= end_y && s.x == start_x;
        along = s.head == HEAD_UP || s.head == HEAD_DOWN;
      end
      if (along && on && !present[s.vid]) begin
        if (bin_ok && hourly[bin] != COUNT_MAX) hourly[bin] = hourly[bin] + 1'b1;
        present[s.vid] = 1'b1;
        r.entered      = 1'b1;
      end
      // leaving the segment clears the flag, whatever the heading
      if (present[s.vid] && !on) present[s.vid] = 1'b0;
    end
    r.bin_count = bin_ok ? hourly[bin] : '0;
    return r;
  endfunction

  always @(posedge clk) begin : track
    sighting_t s;
    tally_t    want;
    tally_t    got;
    if (rst) begin
      road_en    = 1'b0;
      road_horiz = 1'b1;
      start_x    = '0;
      start_y    = '0;
      end_x      = '0;
      end_y      = '0;
      for (int i = 0; i < MAX_VEHICLES; i++) present[i] = 1'b0;
      for (int i = 0; i < NUM_BINS; i++) hourly[i] = '0;
      expected_tallies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROAD_ENABLED:    road_en    = cfg_data[0];
          CFG_ROAD_HORIZONTAL: road_horiz = cfg_data[0];
          CFG_ROAD_START_X:    start_x    = cfg_data;
          CFG_ROAD_START_Y:    start_y    = cfg_data;
          CFG_ROAD_END_X:      end_x      = cfg_data;
          CFG_ROAD_END_Y:      end_y      = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.entered   = m_tdata[0];
        got.bin_count = m_tdata[16:1];
        if (expected_tallies.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual entered %0d bin_count %0d",
                   $time, got.entered, got.bin_count);
          fails = fails + 1;
        end else begin
          want = expected_tallies.pop_front();
          if (got.entered !== want.entered) begin
            $display("%0t: entered mismatch, expected %0d, actual %0d",
                     $time, want.entered, got.entered);
            fails = fails + 1;
          end
          if (got.bin_count !== want.bin_count) begin
            $display("%0t: bin_count mismatch, expected %0d, actual %0d",
                     $time, want.bin_count, got.bin_count);
            fails = fails + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        s.req  = req_t'(s_tuser);
        s.vid  = s_tdata[7:0];
        s.x    = s_tdata[17:8];
        s.y    = s_tdata[27:18];
        s.head = head_t'(s_tdata[29:28]);
        s.day  = s_tdata[34:30];
        s.hour = s_tdata[39:35];
        expected_tallies.push_back(tally_sighting(s));
      end
    end
    waiting = expected_tallies.size();
  end

endmodule

// File: tb/tb_road_entry_hourly_counter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_road_entry_hourly_counter
// drives observe and read requests into the road entry counter under several
// road settings and idle patterns; a checker beside the block predicts every
// result and the top reports the verdict
// ----------------------------------------------------------------------------
module tb_road_entry_hourly_counter;
  import rehc_pkg::*;

  localparam int STALL_LIMIT  = 5000;   // covers the reset clear pass
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 245;
  localparam int SAT_PAIRS    = 30;     // enter and leave pairs on one bin

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  cfg_idx_t               cfg_index = CFG_ROAD_ENABLED;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [39:0]            s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [23:0]            m_tdata;

  int fail_count;
  int pending;
  int send_idle    = 0;  // percent of cycles the request side holds back
  int recv_idle    = 0;  // percent of cycles the result side stalls
  int quiet_cycles = 0;

  // road as last programmed, used to aim requests at the segment
  logic                   road_horiz_now = 1'b1;
  logic [COORD_WIDTH-1:0] sx_now = '0;
  logic [COORD_WIDTH-1:0] sy_now = '0;
  logic [COORD_WIDTH-1:0] ex_now = '0;
  logic [COORD_WIDTH-1:0] ey_now = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  road_entry_hourly_counter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  road_entry_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side backpressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog: too long without any transfer on either stream ends the run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // one register write per cycle; the caller lowers cfg_we afterwards
  task automatic reg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // writes all six road registers back to back, only while the block is idle
  task automatic program_road(input logic en, input logic horiz,
                              input logic [COORD_WIDTH-1:0] sx, input logic [COORD_WIDTH-1:0] sy,
                              input logic [COORD_WIDTH-1:0] ex, input logic [COORD_WIDTH-1:0] ey);
    reg_write(CFG_ROAD_ENABLED,    CFG_DATA_W'(en));
    reg_write(CFG_ROAD_HORIZONTAL, CFG_DATA_W'(horiz));
    reg_write(CFG_ROAD_START_X,    sx);
    reg_write(CFG_ROAD_START_Y,    sy);
    reg_write(CFG_ROAD_END_X,      ex);
    reg_write(CFG_ROAD_END_Y,      ey);
    cfg_we <= 1'b0;
    @(negedge clk);
    road_horiz_now = horiz;
    sx_now = sx;
    sy_now = sy;
    ex_now = ex;
    ey_now = ey;
  endtask

  // one request transfer; tvalid stays up if the next call follows at once
  task automatic send_request(input req_t req, input logic [VID_FIELD_W-1:0] vid,
                              input logic [COORD_WIDTH-1:0] x, input logic [COORD_WIDTH-1:0] y,
                              input head_t head, input logic [DAY_W-1:0] day,
                              input logic [HOUR_W-1:0] hour);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {hour, day, head, y, x, vid};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // stop requests and wait until every result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // mostly vehicles driving onto and off the current road, some reads and noise
  task automatic random_request();
    int                     pick;
    req_t                   req;
    logic [VID_FIELD_W-1:0] vid;
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    head_t                  head;
    logic [DAY_W-1:0]       day;
    logic [HOUR_W-1:0]      hour;
    logic                   coin;
    pick = $urandom_range(99);
    coin = 1'($urandom_range(1));
    req  = REQ_OBSERVE;
    vid  = VID_FIELD_W'($urandom_range(15));  // small fleet so vehicles come back
    day  = DAY_W'(($urandom_range(19) == 0) ? $urandom_range(31, DAYS)
                                            : $urandom_range(DAYS - 1));
    hour = HOUR_W'(($urandom_range(19) == 0) ? $urandom_range(31, HOURS)
                                             : $urandom_range(HOURS - 1));
    // a point on the segment, or on its start when the range is empty
    if (road_horiz_now) begin
      x    = (sx_now <= ex_now) ? COORD_WIDTH'($urandom_range(ex_now, sx_now)) : sx_now;
      y    = sy_now;
      head = coin ? HEAD_RIGHT : HEAD_LEFT;
    end else begin
      x    = sx_now;
      y    = (sy_now <= ey_now) ? COORD_WIDTH'($urandom_range(ey_now, sy_now)) : sy_now;
      head = coin ? HEAD_UP : HEAD_DOWN;
    end
    if (pick < 55) begin
      // entry attempt along the road
    end else if (pick < 70) begin
      // step off the segment sideways, any heading
      if (road_horiz_now) y = COORD_WIDTH'(sy_now + $urandom_range(1023, 1));
      else                x = COORD_WIDTH'(sx_now + $urandom_range(1023, 1));
      head = head_t'($urandom_range(3));
    end else if (pick < 80) begin
      // on the segment but crossing it
      if (road_horiz_now) head = coin ? HEAD_UP : HEAD_DOWN;
      else                head = coin ? HEAD_RIGHT : HEAD_LEFT;
    end else if (pick < 88) begin
      req  = REQ_READ;
      x    = COORD_WIDTH'($urandom);
      y    = COORD_WIDTH'($urandom);
      head = head_t'($urandom_range(3));
    end else begin
      req  = req_t'($urandom_range(1));
      vid  = VID_FIELD_W'($urandom);
      x    = COORD_WIDTH'($urandom);
      y    = COORD_WIDTH'($urandom);
      head = head_t'($urandom_range(3));
      day  = DAY_W'($urandom);
      hour = HOUR_W'($urandom);
    end
    send_request(req, vid, x, y, head, day, hour);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // road still disabled after reset: observation ignored, bins read zero
    send_request(REQ_OBSERVE, 8'd0, 10'd0, 10'd0, HEAD_RIGHT, 5'd0, 5'd0);
    send_request(REQ_READ, 8'd0, 10'd0, 10'd0, HEAD_RIGHT, 5'd0, 5'd0);
    drain();

    // full width horizontal road along y = 0
    program_road(1'b1, 1'b1, 10'd0, 10'd0, 10'd1023, 10'd1023);
    send_request(REQ_OBSERVE, 8'd0,   10'd0,    10'd0, HEAD_RIGHT, 5'd0,  5'd0);
    send_request(REQ_OBSERVE, 8'd0,   10'd0,    10'd0, HEAD_RIGHT, 5'd0,  5'd0);
    send_request(REQ_OBSERVE, 8'd0,   10'd1023, 10'd0, HEAD_LEFT,  5'd0,  5'd0);
    send_request(REQ_OBSERVE, 8'd255, 10'd1023, 10'd0, HEAD_LEFT,  5'd29, 5'd23);
    send_request(REQ_OBSERVE, 8'd1,   10'd5,    10'd0, HEAD_UP,    5'd0,  5'd0);
    send_request(REQ_OBSERVE, 8'd0,   10'd5,    10'd1, HEAD_RIGHT, 5'd0,  5'd0);
    // entry with day and hour out of range: flag set, no bin touched
    send_request(REQ_OBSERVE, 8'd0,   10'd5,    10'd0, HEAD_LEFT,  5'd31, 5'd31);
    send_request(REQ_READ,    8'd0,   10'd0,    10'd0, HEAD_RIGHT, 5'd30, 5'd0);
    send_request(REQ_READ,    8'd0,   10'd0,    10'd0, HEAD_RIGHT, 5'd0,  5'd24);
    send_request(REQ_READ,    8'd0,   10'd0,    10'd0, HEAD_RIGHT, 5'd0,  5'd0);
    send_request(REQ_READ,    8'd0,   10'd0,    10'd0, HEAD_RIGHT, 5'd29, 5'd23);
    send_request(REQ_OBSERVE, 8'd0,   10'd1023, 10'd1023, HEAD_DOWN, 5'd0, 5'd0);
    drain();

    // disabled again: an entry that would count is ignored
    program_road(1'b0, 1'b1, 10'd0, 10'd0, 10'd1023, 10'd1023);
    send_request(REQ_OBSERVE, 8'd9, 10'd3, 10'd0, HEAD_RIGHT, 5'd0, 5'd0);
    drain();

    // full height vertical road along x = 1023
    program_road(1'b1, 1'b0, 10'd1023, 10'd0, 10'd1023, 10'd1023);
    send_request(REQ_OBSERVE, 8'd2, 10'd1023, 10'd512,  HEAD_UP,    5'd1, 5'd1);
    send_request(REQ_OBSERVE, 8'd3, 10'd1023, 10'd512,  HEAD_RIGHT, 5'd1, 5'd1);
    send_request(REQ_OBSERVE, 8'd3, 10'd1023, 10'd1023, HEAD_DOWN,  5'd1, 5'd1);
    send_request(REQ_OBSERVE, 8'd2, 10'd1022, 10'd512,  HEAD_UP,    5'd1, 5'd1);
    drain();

    // start beyond end: empty segment, nothing can enter
    program_road(1'b1, 1'b1, 10'd700, 10'd500, 10'd300, 10'd500);
    send_request(REQ_OBSERVE, 8'd4, 10'd500, 10'd500, HEAD_RIGHT, 5'd2, 5'd2);
    drain();

    // random traffic: two roads per idle pattern
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin send_idle = 35; recv_idle = 58; end
        1: begin send_idle = 58; recv_idle = 35; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (seg)
        0: begin : horiz_rand
          logic [COORD_WIDTH-1:0] lo;
          lo = COORD_WIDTH'($urandom_range(400));
          program_road(1'b1, 1'b1, lo, COORD_WIDTH'($urandom),
                       COORD_WIDTH'(lo + $urandom_range(300)), COORD_WIDTH'($urandom));
        end
        1: begin : vert_rand
          logic [COORD_WIDTH-1:0] lo;
          lo = COORD_WIDTH'($urandom_range(500));
          program_road(1'b1, 1'b0, COORD_WIDTH'($urandom), lo, COORD_WIDTH'($urandom),
                       COORD_WIDTH'(lo + $urandom_range(400)));
        end
        2: program_road(1'b1, 1'b1, 10'd0, 10'd1023, 10'd1023, 10'd0);
        3: begin : vert_point
          logic [COORD_WIDTH-1:0] pt;
          pt = COORD_WIDTH'($urandom);
          program_road(1'b1, 1'b0, COORD_WIDTH'($urandom), pt, COORD_WIDTH'($urandom), pt);
        end
        4: program_road(1'b1, 1'b0, 10'd0, 10'd0, 10'd1023, 10'd1023);
        default: begin : horiz_late
          logic [COORD_WIDTH-1:0] lo;
          lo = COORD_WIDTH'($urandom_range(600));
          program_road(1'b1, 1'b1, lo, COORD_WIDTH'($urandom),
                       COORD_WIDTH'(lo + $urandom_range(400)), COORD_WIDTH'($urandom));
        end
      endcase
      repeat (PHASE_ITEMS) random_request();
      drain();
    end

    // enter and leave pairs on one bin back to back, no idling
    program_road(1'b1, 1'b1, 10'd10, 10'd20, 10'd30, 10'd20);
    for (int i = 0; i < SAT_PAIRS; i++) begin
      send_request(REQ_OBSERVE, i[7:0], 10'd15, 10'd20, HEAD_RIGHT, 5'd7, 5'd13);
      send_request(REQ_OBSERVE, i[7:0], 10'd15, 10'd21, HEAD_RIGHT, 5'd7, 5'd13);
    end
    send_request(REQ_READ, 8'd0, 10'd0, 10'd0, HEAD_RIGHT, 5'd7, 5'd13);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
